[hw/rtl/sss_pkg.sv]
// Shared types and constants of the stepper step sequencer.
// No dependencies; every other file of the block imports this package.
package sss_pkg;

  localparam int unsigned POS_W      = 5;
  localparam int unsigned DUTY_W     = 12;
  localparam int unsigned CURVE_W    = 8;
  localparam int unsigned CURVE_N    = 8;
  localparam int unsigned CFG_DATA_W = CURVE_W * CURVE_N;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned COIL_W     = 4;

  localparam logic CMD_STEP    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] STYLE_SINGLE     = 2'd0;
  localparam logic [1:0] STYLE_DOUBLE     = 2'd1;
  localparam logic [1:0] STYLE_INTERLEAVE = 2'd2;
  localparam logic [1:0] STYLE_MICROSTEP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_TOP = 1'b1;

  localparam logic [CURVE_W-1:0] CURVE_TOP_RST = 8'd255;
  localparam logic [DUTY_W-1:0]  FULL_DUTY     = 12'd4080;

  typedef logic [COIL_W-1:0] coil_t;

  // Half-step coil sequence: A, AB, B, BC, C, CD, D, DA
  localparam coil_t COIL_TABLE [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             micro;
  } sss_step_t;

  // Quotient of value by a constant divisor: count of multiples 1..n not above value.
  function automatic logic [POS_W-1:0] count_multiples(logic [POS_W-1:0] value,
                                                       int unsigned divisor,
                                                       int unsigned n);
    logic [POS_W-1:0] cnt;
    cnt = '0;
    for (int unsigned k = 1; k <= n; k++) begin
      if (value >= POS_W'(k * divisor)) begin
        cnt = POS_W'(k);
      end
    end
    return cnt;
  endfunction

endpackage

[hw/rtl/sss_if.sv]
// Handshake channels of the stepper step sequencer: command words in, result words out.
// Depends on sss_pkg for field widths.
interface sss_cmd_if import sss_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       command;
  logic       direction;
  logic [1:0] style;

  modport source (output valid, command, direction, style, input ready);
  modport sink   (input valid, command, direction, style, output ready);
endinterface

interface sss_res_if import sss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic              duty_written;
  logic              drive_a_in2;
  logic              drive_b_in1;
  logic              drive_a_in1;
  logic              drive_b_in2;

  modport source (output valid, position, duty_a, duty_b, duty_written,
                  drive_a_in2, drive_b_in1, drive_a_in1, drive_b_in2, input ready);
  modport sink   (input valid, position, duty_a, duty_b, duty_written,
                  drive_a_in2, drive_b_in1, drive_a_in1, drive_b_in2, output ready);
endinterface

[hw/rtl/sss_step_calc.sv]
// Next rotor position for one step command: step size by style, wrap over one cycle.
// Depends on sss_pkg.
module sss_step_calc import sss_pkg::*; #(
  parameter int unsigned MICROSTEPS = 8
) (
  input  logic [POS_W-1:0] pos_i,
  input  logic             direction_i,
  input  logic [1:0]       style_i,
  output sss_step_t        step_o
);

  localparam int unsigned HALF   = MICROSTEPS / 2;
  localparam int unsigned CYCLE  = 4 * MICROSTEPS;
  localparam int unsigned HIDX_N = (CYCLE - 1) / HALF;
  localparam int unsigned SIZE_W = $clog2(MICROSTEPS + 1);

  logic [POS_W-1:0]  hidx;
  logic [SIZE_W-1:0] size;
  logic [POS_W:0]    fwd;
  logic [POS_W:0]    nxt;

  assign hidx = count_multiples(pos_i, HALF, HIDX_N);

  always_comb begin
    case (style_i)
      STYLE_SINGLE:     size = hidx[0] ? SIZE_W'(HALF) : SIZE_W'(MICROSTEPS);
      STYLE_DOUBLE:     size = hidx[0] ? SIZE_W'(MICROSTEPS) : SIZE_W'(HALF);
      STYLE_INTERLEAVE: size = SIZE_W'(HALF);
      default:          size = SIZE_W'(1);
    endcase
  end

  // Wrap with one compare and subtract or add of the cycle length
  always_comb begin
    fwd = {1'b0, pos_i} + (POS_W+1)'(size);
    if (direction_i) begin
      if ({1'b0, pos_i} >= (POS_W+1)'(size)) begin
        nxt = {1'b0, pos_i} - (POS_W+1)'(size);
      end else begin
        nxt = {1'b0, pos_i} + (POS_W+1)'(CYCLE) - (POS_W+1)'(size);
      end
    end else begin
      if (fwd >= (POS_W+1)'(CYCLE)) begin
        nxt = fwd - (POS_W+1)'(CYCLE);
      end else begin
        nxt = fwd;
      end
    end
  end

  assign step_o.pos   = nxt[POS_W-1:0];
  assign step_o.micro = (style_i == STYLE_MICROSTEP);

endmodule

[hw/rtl/sss_drive_map.sv]
// Bridge duties and coil pattern for a new rotor position.
// Depends on sss_pkg (coil table, widths).
module sss_drive_map import sss_pkg::*; #(
  parameter int unsigned MICROSTEPS = 8
) (
  input  sss_step_t             step_i,
  input  logic [CFG_DATA_W-1:0] curve_low_i,
  input  logic [CURVE_W-1:0]    curve_top_i,
  output logic [DUTY_W-1:0]     duty_a_o,
  output logic [DUTY_W-1:0]     duty_b_o,
  output coil_t                 coils_o
);

  localparam int unsigned HALF   = MICROSTEPS / 2;
  localparam int unsigned CYCLE  = 4 * MICROSTEPS;
  localparam int unsigned HIDX_N = (CYCLE - 1) / HALF;
  localparam int unsigned IDX_W  = $clog2(MICROSTEPS + 1);

  logic [CURVE_W-1:0] curve_byte [CURVE_N];
  logic [POS_W-1:0]   quad_full;
  logic [1:0]         quad;
  logic [POS_W-1:0]   rem_full;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx_m;
  logic [CURVE_W-1:0] val_r;
  logic [CURVE_W-1:0] val_m;
  logic [POS_W-1:0]   hidx;

  for (genvar i = 0; i < CURVE_N; i++) begin : g_byte
    assign curve_byte[i] = curve_low_i[CURVE_W*i +: CURVE_W];
  end

  function automatic logic [CURVE_W-1:0] curve_at(logic [IDX_W-1:0] idx);
    logic [2:0] sel;
    sel = 3'(idx);
    if (idx >= IDX_W'(MICROSTEPS)) begin
      return curve_top_i;
    end
    return curve_byte[sel];
  endfunction

  assign quad_full = count_multiples(step_i.pos, MICROSTEPS, 3);
  assign quad      = quad_full[1:0];
  assign rem_full  = step_i.pos - POS_W'(MICROSTEPS * quad);
  assign idx_r     = rem_full[IDX_W-1:0];
  assign idx_m     = IDX_W'(MICROSTEPS) - idx_r;
  assign val_r     = curve_at(idx_r);
  assign val_m     = curve_at(idx_m);
  assign hidx      = count_multiples(step_i.pos, HALF, HIDX_N);

  always_comb begin
    if (step_i.micro) begin
      // Even quadrant: A falls from full scale while B rises; odd swaps them
      if (!quad[0]) begin
        duty_a_o = {val_m, 4'b0};
        duty_b_o = {val_r, 4'b0};
      end else begin
        duty_a_o = {val_r, 4'b0};
        duty_b_o = {val_m, 4'b0};
      end
      coils_o = COIL_TABLE[{quad, 1'b1}];
    end else begin
      duty_a_o = FULL_DUTY;
      duty_b_o = FULL_DUTY;
      coils_o  = COIL_TABLE[hidx[2:0]];
    end
  end

endmodule

[hw/rtl/stepper_step_sequencer_unit.sv]
// Top level of the stepper step sequencer: command register, position state, result register.
// Depends on sss_pkg, sss_if, sss_step_calc and sss_drive_map.

// Takes one command word per clock and returns one result word for each, in order.
// A word passes an input register and then a result register before its result is
// offered; with the result side ready the block sustains one word every cycle.
// A step moves the rotor position (modulo 4*MICROSTEPS) and reports the new position,
// both bridge duties and the coil bits; a release zeroes duties and coils and keeps
// the position. Write curve registers only while no command is in flight.
module stepper_step_sequencer_unit import sss_pkg::*; #(
  parameter int unsigned MICROSTEPS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sss_cmd_if.sink               cmd_i,
  sss_res_if.source             res_o
);

  localparam int unsigned CYCLE = 4 * MICROSTEPS;

  logic [CFG_DATA_W-1:0] curve_low_q;
  logic [CURVE_W-1:0]    curve_top_q;
  logic [POS_W-1:0]      pos_q, pos_d;

  logic       s1_valid_q;
  logic       s1_cmd_q;
  logic       s1_dir_q;
  logic [1:0] s1_style_q;

  logic       out_valid_q;
  logic       out_en;
  logic       in_en;

  sss_step_t         step;
  logic [DUTY_W-1:0] duty_a, duty_b;
  coil_t             coils;

  logic [POS_W-1:0]  position_q;
  logic [DUTY_W-1:0] duty_a_q, duty_b_q;
  logic              written_q;
  coil_t             coils_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_low_q <= '0;
      curve_top_q <= CURVE_TOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CURVE_LOW: curve_low_q <= cfg_data_i;
        CFG_CURVE_TOP: curve_top_q <= cfg_data_i[CURVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the result register when it is empty or being drained
  assign out_en      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_en       = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !s1_valid_q || out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      s1_cmd_q   <= cmd_i.command;
      s1_dir_q   <= cmd_i.direction;
      s1_style_q <= cmd_i.style;
    end
  end

  sss_step_calc #(.MICROSTEPS(MICROSTEPS)) u_calc (
    .pos_i       (pos_q),
    .direction_i (s1_dir_q),
    .style_i     (s1_style_q),
    .step_o      (step)
  );

  sss_drive_map #(.MICROSTEPS(MICROSTEPS)) u_map (
    .step_i      (step),
    .curve_low_i (curve_low_q),
    .curve_top_i (curve_top_q),
    .duty_a_o    (duty_a),
    .duty_b_o    (duty_b),
    .coils_o     (coils)
  );

  // Hold the position on release
  assign pos_d = (out_en && s1_cmd_q == CMD_STEP) ? step.pos : pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (out_en) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      if (s1_cmd_q == CMD_RELEASE) begin
        position_q <= pos_q;
        duty_a_q   <= '0;
        duty_b_q   <= '0;
        written_q  <= 1'b0;
        coils_q    <= '0;
      end else begin
        position_q <= step.pos;
        duty_a_q   <= duty_a;
        duty_b_q   <= duty_b;
        written_q  <= 1'b1;
        coils_q    <= coils;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.position     = position_q;
  assign res_o.duty_a       = duty_a_q;
  assign res_o.duty_b       = duty_b_q;
  assign res_o.duty_written = written_q;
  assign res_o.drive_a_in2  = coils_q[0];
  assign res_o.drive_b_in1  = coils_q[1];
  assign res_o.drive_a_in1  = coils_q[2];
  assign res_o.drive_b_in2  = coils_q[3];

`ifndef SYNTH
  a_pos_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (POS_W+1)'(CYCLE))
    else $error("rotor position outside one electrical cycle");

  a_release_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_en && s1_cmd_q == CMD_RELEASE |=> $stable(pos_q))
    else $error("release moved the rotor position");

  a_release_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !written_q |-> coils_q == '0 && duty_a_q == '0 && duty_b_q == '0)
    else $error("release result drives a coil or duty");

  a_step_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && written_q |-> $countones(coils_q) == 1 || $countones(coils_q) == 2)
    else $error("step result has an invalid coil pattern");

  a_result_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_en |=> position_q == pos_q)
    else $error("reported position differs from rotor state");
`endif

endmodule
